### rtl/core/hrcf_pkg.sv
`default_nettype none

package hrcf_pkg;

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned HdrLimW  = 16;
  localparam int unsigned BodyLimW = 24;
  localparam int unsigned LenW     = 25;
  localparam int unsigned HdrCntW  = 17;
  localparam int unsigned CfgDataW = 24;

  // Length name, matched without regard to case
  localparam int unsigned NameLen = 15;
  localparam int unsigned NameIdxW = 4;
  localparam logic [NameLen*ByteW-1:0] NameStr = "content-length:";

  // Saturation values
  localparam logic [LenW-1:0]    LenSat     = 25'd16777216;
  localparam logic [HdrCntW-1:0] HdrCntMax  = '1;
  localparam logic [LenW-1:0]    BodyCntMax = '1;

  // Configuration register indexes
  localparam logic CfgHeaderLimit = 1'b0;
  localparam logic CfgBodyLimit   = 1'b1;

  // Result status codes
  localparam logic [1:0] StatIncomplete = 2'd0;
  localparam logic [1:0] StatComplete   = 2'd1;
  localparam logic [1:0] StatHdrBig     = 2'd2;
  localparam logic [1:0] StatBodyBig    = 2'd3;

  // Characters
  localparam logic [ByteW-1:0] ChCr    = 8'h0d;
  localparam logic [ByteW-1:0] ChLf    = 8'h0a;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChUpA   = 8'h41;
  localparam logic [ByteW-1:0] ChUpZ   = 8'h5a;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             first_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [LenW-1:0] declared_length;
  } rsp_t;

  // Classified byte passed from front to back; name_hit has a spare top bit
  typedef struct packed {
    logic             first;
    logic [NameLen:0] name_hit;
    logic             is_cr;
    logic             is_lf;
    logic             is_blank;
    logic             is_digit;
    logic [3:0]       digit;
  } byte_class_t;

  function automatic logic [ByteW-1:0] name_char(input logic [NameIdxW-1:0] k);
    logic [NameLen*ByteW-1:0] sh;
    sh = NameStr >> ((NameLen - 1 - 32'(k)) * ByteW);
    return sh[ByteW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/hrcf_front.sv
`default_nettype none

module hrcf_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire hrcf_pkg::req_t       in_data_i,
  output logic                      push_o,
  output hrcf_pkg::byte_class_t     push_data_o,
  input  wire logic                 full_i
);
  import hrcf_pkg::*;

  logic          valid_q;
  byte_class_t   cls_q;
  byte_class_t   cls_d;
  logic [ByteW-1:0] lower;

  // Classify the incoming byte
  always_comb begin
    lower = in_data_i.data_byte;
    if (in_data_i.data_byte >= ChUpA && in_data_i.data_byte <= ChUpZ) begin
      lower = in_data_i.data_byte + 8'd32;
    end
    cls_d.first    = in_data_i.first_byte;
    cls_d.is_cr    = (in_data_i.data_byte == ChCr);
    cls_d.is_lf    = (in_data_i.data_byte == ChLf);
    cls_d.is_blank = (in_data_i.data_byte == ChSpace) || (in_data_i.data_byte == ChTab);
    cls_d.is_digit = (in_data_i.data_byte >= ChZero) && (in_data_i.data_byte <= ChNine);
    cls_d.digit    = 4'(in_data_i.data_byte - ChZero);
    cls_d.name_hit = '0;
    for (int k = 0; k < NameLen; k++) begin
      cls_d.name_hit[k] = (lower == name_char(NameIdxW'(k)));
    end
  end

  assign push_o      = valid_q && !full_i;
  assign push_data_o = cls_q;
  assign in_ready_o  = !valid_q || !full_i;

  // Hold the classified byte until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cls_q <= cls_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hrcf_queue.sv
`default_nettype none

module hrcf_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire hrcf_pkg::byte_class_t push_data_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output logic                       empty_o,
  output hrcf_pkg::byte_class_t      pop_data_o
);
  import hrcf_pkg::*;

  byte_class_t mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

### rtl/core/hrcf_back.sv
`default_nettype none

module hrcf_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  empty_i,
  input  wire hrcf_pkg::byte_class_t item_i,
  output logic                       pop_o,
  input  wire logic [hrcf_pkg::HdrLimW-1:0]  hdr_limit_i,
  input  wire logic [hrcf_pkg::BodyLimW-1:0] body_limit_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output hrcf_pkg::rsp_t             out_data_o
);
  import hrcf_pkg::*;

  // Request phase
  localparam logic [2:0] PhHeader  = 3'd0;
  localparam logic [2:0] PhBody    = 3'd1;
  localparam logic [2:0] PhDone    = 3'd2;
  localparam logic [2:0] PhHdrBig  = 3'd3;
  localparam logic [2:0] PhBodyBig = 3'd4;

  // Length field progress
  localparam logic [1:0] LfSearch = 2'd0;
  localparam logic [1:0] LfBlanks = 2'd1;
  localparam logic [1:0] LfDigits = 2'd2;
  localparam logic [1:0] LfEnded  = 2'd3;

  logic [2:0]          ph_q, ph_d;
  logic [1:0]          blm_q, blm_d;
  logic [NameIdxW-1:0] nmi_q, nmi_d;
  logic [1:0]          lfs_q, lfs_d;
  logic [LenW-1:0]     acc_q, acc_d;
  logic [HdrCntW-1:0]  hcnt_q, hcnt_d;
  logic [LenW-1:0]     bcnt_q, bcnt_d;
  logic                out_valid_q;
  rsp_t                out_q, out_d;

  assign pop_o       = !empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Step the framer by one byte
  always_comb begin
    logic [2:0]          ph;
    logic [1:0]          blm;
    logic [NameIdxW-1:0] nmi;
    logic [1:0]          lfs;
    logic [LenW-1:0]     acc;
    logic [HdrCntW-1:0]  hcnt;
    logic [LenW-1:0]     bcnt;
    logic [NameIdxW:0]   nmi_w;
    logic [2:0]          m;
    logic                term;
    logic [LenW+2:0]     prod;
    logic [1:0]          st;

    // Start from cleared state on the first byte of a request
    ph   = item_i.first ? PhHeader : ph_q;
    blm  = item_i.first ? 2'd0 : blm_q;
    nmi  = item_i.first ? '0 : nmi_q;
    lfs  = item_i.first ? LfSearch : lfs_q;
    acc  = item_i.first ? '0 : acc_q;
    hcnt = item_i.first ? '0 : hcnt_q;
    bcnt = item_i.first ? '0 : bcnt_q;
    nmi_w = '0;
    m     = '0;
    term  = 1'b0;
    prod  = '0;

    if (ph == PhHeader) begin
      if (hcnt < HdrCntMax) begin
        hcnt = hcnt + HdrCntW'(1);
      end

      // Track the length field
      case (lfs)
        LfSearch: begin
          if (32'(nmi) < NameLen && item_i.name_hit[nmi]) begin
            nmi_w = {1'b0, nmi} + (NameIdxW+1)'(1);
          end else begin
            nmi_w = item_i.name_hit[0] ? (NameIdxW+1)'(1) : '0;
          end
          if (32'(nmi_w) >= NameLen) begin
            nmi = '0;
            lfs = LfBlanks;
          end else begin
            nmi = nmi_w[NameIdxW-1:0];
          end
        end
        LfBlanks: begin
          if (!item_i.is_blank) begin
            if (item_i.is_digit) begin
              acc = LenW'(item_i.digit);
              lfs = LfDigits;
            end else begin
              acc = '0;
              lfs = LfEnded;
            end
          end
        end
        LfDigits: begin
          if (item_i.is_digit) begin
            prod = {acc, 3'b000} + {2'b00, acc, 1'b0} + (LenW+3)'(item_i.digit);
            acc  = (prod > (LenW+3)'(LenSat)) ? LenSat : prod[LenW-1:0];
          end else begin
            lfs = LfEnded;
          end
        end
        default: begin
        end
      endcase

      // Match the blank line that ends the header
      if ((blm == 2'd0 || blm == 2'd2) && item_i.is_cr) begin
        m = {1'b0, blm} + 3'd1;
      end else if ((blm == 2'd1 || blm == 2'd3) && item_i.is_lf) begin
        m = {1'b0, blm} + 3'd1;
      end else begin
        m = item_i.is_cr ? 3'd1 : 3'd0;
      end
      term = (m == 3'd4);
      blm  = term ? 2'd0 : m[1:0];

      // Decide the phase
      if (term) begin
        if ((hcnt - HdrCntW'(4)) > HdrCntW'(hdr_limit_i)) begin
          ph = PhHdrBig;
        end else if (acc > LenW'(body_limit_i)) begin
          ph = PhBodyBig;
        end else if (acc == '0) begin
          ph = PhDone;
        end else begin
          ph = PhBody;
        end
      end else if (hcnt > HdrCntW'(hdr_limit_i)) begin
        ph = PhHdrBig;
      end
    end else if (ph == PhBody) begin
      if (bcnt < BodyCntMax) begin
        bcnt = bcnt + LenW'(1);
      end
      if (bcnt >= acc) begin
        ph = PhDone;
      end
    end

    case (ph)
      PhDone:    st = StatComplete;
      PhHdrBig:  st = StatHdrBig;
      PhBodyBig: st = StatBodyBig;
      default:   st = StatIncomplete;
    endcase

    ph_d   = ph;
    blm_d  = blm;
    nmi_d  = nmi;
    lfs_d  = lfs;
    acc_d  = acc;
    hcnt_d = hcnt;
    bcnt_d = bcnt;
    out_d.status          = st;
    out_d.declared_length = acc;
  end

  // Update state on each consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhHeader;
      blm_q  <= 2'd0;
      nmi_q  <= '0;
      lfs_q  <= LfSearch;
      acc_q  <= '0;
      hcnt_q <= '0;
      bcnt_q <= '0;
    end else if (pop_o) begin
      ph_q   <= ph_d;
      blm_q  <= blm_d;
      nmi_q  <= nmi_d;
      lfs_q  <= lfs_d;
      acc_q  <= acc_d;
      hcnt_q <= hcnt_d;
      bcnt_q <= bcnt_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_name_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nmi_q) < NameLen)
    else $error("name match index out of range");
  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PhBody) |-> (acc_q != '0) && (bcnt_q < acc_q))
    else $error("body phase with finished or empty length");
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !item_i.first && (ph_q == PhHdrBig || ph_q == PhBodyBig))
      |=> $stable(ph_q))
    else $error("rejected request left its phase without a new request");
`endif

endmodule

`default_nettype wire

### rtl/core/http_request_completion_framer_unit.sv
`default_nettype none

// Request framer: takes request bytes and returns one result per byte with
// the status (incomplete, complete, header too large, body too large) and the
// content length parsed so far. A byte marked first_byte starts a new request.
// Bytes are accepted at one per cycle sustained while out_ready holds; each
// result passes through the input classify register, a two-entry queue and the
// framer state update into the output register. Input and output stall
// independently through the queue. The user must write header_limit and
// body_limit via the cfg port while no request is in flight; not enforced.
module http_request_completion_framer_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire hrcf_pkg::req_t                  in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output hrcf_pkg::rsp_t                       out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_index_i,
  input  wire logic [hrcf_pkg::CfgDataW-1:0]   cfg_data_i
);
  import hrcf_pkg::*;

  logic [HdrLimW-1:0]  hdr_limit_q;
  logic [BodyLimW-1:0] body_limit_q;
  logic                push;
  byte_class_t         push_data;
  logic                full;
  logic                pop;
  logic                empty;
  byte_class_t         pop_data;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_limit_q  <= 16'd8192;
      body_limit_q <= 24'd1048576;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgHeaderLimit: hdr_limit_q  <= cfg_data_i[HdrLimW-1:0];
        CfgBodyLimit:   body_limit_q <= cfg_data_i[BodyLimW-1:0];
        default: begin
        end
      endcase
    end
  end

  hrcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  hrcf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  hrcf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .item_i       (pop_data),
    .pop_o        (pop),
    .hdr_limit_i  (hdr_limit_q),
    .body_limit_i (body_limit_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
